/* design/sha1_byte_stream_hasher_unit_assert.svh */
// Assertion macros for the SHA-1 byte stream hasher.
`ifndef SHA1_BYTE_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA1_BYTE_STREAM_HASHER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SHA1BSH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SHA1BSH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sha1bsh_pkg.sv */
package sha1bsh_pkg;

    // Initial chaining values h0..h4
    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // Round constants, one per group of twenty rounds
    localparam logic [31:0] K_ROUND [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [5:0] FILL_LAST   = 6'd63;
    localparam logic [2:0] LEN_ZONE    = 3'd7;   // fill[5:3] of byte slots 56..63
    localparam logic [6:0] ROUND_LAST  = 7'd79;
    localparam logic [2:0] WORD_LAST   = 3'd4;
    localparam logic [63:0] LEN_STEP   = 64'd8;

    // Round groups: choose, parity, majority, parity
    typedef enum logic [1:0] {
        RG_CHOOSE = 2'd0,
        RG_PAR1   = 2'd1,
        RG_MAJ    = 2'd2,
        RG_PAR2   = 2'd3
    } t_round_grp;

    // Source of a byte written into the block
    typedef enum logic [1:0] {
        BSRC_IN   = 2'd0,
        BSRC_PAD  = 2'd1,
        BSRC_ZERO = 2'd2,
        BSRC_LEN  = 2'd3
    } t_byte_src;

    typedef struct packed {
        logic       byte_wr;
        t_byte_src  byte_src;
        logic       len_add;
        logic       round_load;
        logic       round_en;
        t_round_grp round_grp;
        logic       cv_add;
        logic       cv_init;
        logic [2:0] word_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0] fill;
    } t_dp_sts;

endpackage

/* design/sha1bsh_datapath.sv */
module sha1bsh_datapath
    import sha1bsh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [7:0]  i_data_byte,
    output t_dp_sts     o_sts,
    output logic [31:0] o_digest_word
);

    logic [31:0] r_cv [5];
    logic [5:0]  r_fill;
    logic [63:0] r_len;
    logic [31:0] r_w [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;

    logic [7:0]  wr_byte;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] tmp;
    logic [31:0] w_mix;
    logic [31:0] w_new;
    logic [3:0]  wr_word;
    logic [4:0]  wr_lane;
    logic [5:0]  len_lsb;

    // Pick the byte going into the block
    assign len_lsb = {~r_fill[2:0], 3'b000};
    always_comb begin
        case (i_cmd.byte_src)
            BSRC_IN:   wr_byte = i_data_byte;
            BSRC_PAD:  wr_byte = PAD_BYTE;
            BSRC_ZERO: wr_byte = 8'h00;
            BSRC_LEN:  wr_byte = r_len[len_lsb +: 8];
            default:   wr_byte = 8'h00;
        endcase
    end

    // Big-endian placement: byte 0 of a word sits in bits 31:24
    assign wr_word = r_fill[5:2];
    assign wr_lane = {~r_fill[1:0], 3'b000};

    // Round function and constant
    always_comb begin
        case (i_cmd.round_grp)
            RG_CHOOSE: f_val = (r_b & r_c) | (~r_b & r_d);
            RG_MAJ:    f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            default:   f_val = r_b ^ r_c ^ r_d;
        endcase
        k_val = K_ROUND[i_cmd.round_grp];
    end

    assign tmp   = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + r_w[0];
    assign w_mix = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign w_new = {w_mix[30:0], w_mix[31]};

    // Chaining values, fill count and bit length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) r_cv[i] <= H_INIT[i];
            r_fill <= '0;
            r_len  <= '0;
        end else if (i_cmd.cv_init) begin
            for (int i = 0; i < 5; i++) r_cv[i] <= H_INIT[i];
            r_fill <= '0;
            r_len  <= '0;
        end else begin
            if (i_cmd.cv_add) begin
                r_cv[0] <= r_cv[0] + r_a;
                r_cv[1] <= r_cv[1] + r_b;
                r_cv[2] <= r_cv[2] + r_c;
                r_cv[3] <= r_cv[3] + r_d;
                r_cv[4] <= r_cv[4] + r_e;
            end
            if (i_cmd.byte_wr) r_fill <= r_fill + 6'd1;
            if (i_cmd.len_add) r_len  <= r_len + LEN_STEP;
        end
    end

    // Block words: byte fill, then a sliding schedule window during rounds
    always_ff @(posedge i_clk) begin
        if (i_cmd.byte_wr) begin
            r_w[wr_word][wr_lane +: 8] <= wr_byte;
        end else if (i_cmd.round_en) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
        end
    end

    // Working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.round_load) begin
            r_a <= r_cv[0];
            r_b <= r_cv[1];
            r_c <= r_cv[2];
            r_d <= r_cv[3];
            r_e <= r_cv[4];
        end else if (i_cmd.round_en) begin
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= tmp;
        end
    end

    // Digest word select
    always_comb begin
        case (i_cmd.word_sel)
            3'd0:    o_digest_word = r_cv[0];
            3'd1:    o_digest_word = r_cv[1];
            3'd2:    o_digest_word = r_cv[2];
            3'd3:    o_digest_word = r_cv[3];
            3'd4:    o_digest_word = r_cv[4];
            default: o_digest_word = r_cv[0];
        endcase
    end

    assign o_sts.fill = r_fill;

endmodule

/* design/sha1bsh_ctrl.sv */
module sha1bsh_ctrl
    import sha1bsh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_byte_present,
    input  logic       i_message_end,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_word_index,
    output logic       o_last_word,
    output t_dp_cmd    o_cmd,
    input  t_dp_sts    i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_CINIT,
        S_ROUND,
        S_CADD,
        S_EMIT
    } t_state;

    t_state     r_state, n_state;
    logic [6:0] r_round, n_round;
    logic [2:0] r_idx, n_idx;
    logic       r_pad, n_pad;
    logic       r_first, n_first;
    logic       r_len_ok, n_len_ok;
    logic       r_fin, n_fin;

    logic       in_acc;
    logic       out_acc;
    logic       blk_full;
    logic       len_zone;
    t_byte_src  pad_src;

    assign in_acc   = i_valid && !o_stall;
    assign out_acc  = o_valid && !i_stall;
    assign blk_full = (i_sts.fill == FILL_LAST);
    assign len_zone = (i_sts.fill[5:3] == LEN_ZONE);

    // Padding byte: marker first, length once past the marker's block zone
    always_comb begin
        if (r_first)                 pad_src = BSRC_PAD;
        else if (len_zone && r_len_ok) pad_src = BSRC_LEN;
        else                         pad_src = BSRC_ZERO;
    end

    // Next state and datapath commands
    always_comb begin
        n_state  = r_state;
        n_round  = r_round;
        n_idx    = r_idx;
        n_pad    = r_pad;
        n_first  = r_first;
        n_len_ok = r_len_ok;
        n_fin    = r_fin;
        o_cmd    = '0;
        o_cmd.byte_src  = BSRC_IN;
        o_cmd.round_grp = RG_CHOOSE;
        o_cmd.word_sel  = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.byte_wr = i_byte_present;
                    o_cmd.len_add = i_byte_present;
                    if (i_byte_present && blk_full) begin
                        n_state = S_CINIT;
                        n_pad   = i_message_end;
                        n_first = i_message_end;
                    end else if (i_message_end) begin
                        n_state = S_PAD;
                        n_pad   = 1'b1;
                        n_first = 1'b1;
                    end
                end
            end
            S_PAD: begin
                o_cmd.byte_wr  = 1'b1;
                o_cmd.byte_src = pad_src;
                n_first = 1'b0;
                if (!len_zone) n_len_ok = 1'b1;
                if (blk_full) begin
                    n_state = S_CINIT;
                    if (pad_src == BSRC_LEN) n_fin = 1'b1;
                end
            end
            S_CINIT: begin
                o_cmd.round_load = 1'b1;
                n_round = '0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round_en = 1'b1;
                if (r_round < 7'd20)      o_cmd.round_grp = RG_CHOOSE;
                else if (r_round < 7'd40) o_cmd.round_grp = RG_PAR1;
                else if (r_round < 7'd60) o_cmd.round_grp = RG_MAJ;
                else                      o_cmd.round_grp = RG_PAR2;
                n_round = r_round + 7'd1;
                if (r_round == ROUND_LAST) n_state = S_CADD;
            end
            S_CADD: begin
                o_cmd.cv_add = 1'b1;
                if (r_fin)      n_state = S_EMIT;
                else if (r_pad) n_state = S_PAD;
                else            n_state = S_IDLE;
            end
            S_EMIT: begin
                if (out_acc) begin
                    if (r_idx == WORD_LAST) begin
                        o_cmd.cv_init = 1'b1;
                        n_idx    = '0;
                        n_pad    = 1'b0;
                        n_first  = 1'b0;
                        n_len_ok = 1'b0;
                        n_fin    = 1'b0;
                        n_state  = S_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_round  <= '0;
            r_idx    <= '0;
            r_pad    <= 1'b0;
            r_first  <= 1'b0;
            r_len_ok <= 1'b0;
            r_fin    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_round  <= n_round;
            r_idx    <= n_idx;
            r_pad    <= n_pad;
            r_first  <= n_first;
            r_len_ok <= n_len_ok;
            r_fin    <= n_fin;
        end
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = (r_state == S_EMIT);
    assign o_word_index = r_idx;
    assign o_last_word  = (r_idx == WORD_LAST);

endmodule

/* design/sha1_byte_stream_hasher_unit.sv */
// SHA-1 over a byte stream.
// Input channel (i_valid / o_stall): one word per accepted item carries a
// message byte, a byte-present flag and a message-end flag. Output channel
// (o_valid / i_stall): five digest words h0..h4 per message, index 0..4,
// o_last_word on the fifth.
// Timing: items that do not complete a 64-byte block are taken one per
// cycle. An item that completes a block runs through the write, a load of
// the working variables, 80 rounds through the single round unit, and the
// chaining add. At message end the block is padded one byte per cycle up
// to its end, with one or two compressions, then the five words follow,
// one per cycle when not stalled.
// While the receiver stalls, the current digest word holds and the block
// takes no input. After the last word the chaining values, length and fill
// return to their initial values for the next message.
// Reset (synchronous, active low) loads the initial chaining values and
// clears the length and the fill count; no clearing pass is needed.
`include "sha1_byte_stream_hasher_unit_assert.svh"

module sha1_byte_stream_hasher_unit
    import sha1bsh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_message_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    sha1bsh_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_byte_present (i_byte_present),
        .i_message_end  (i_message_end),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_word_index   (o_word_index),
        .o_last_word    (o_last_word),
        .o_cmd          (dp_cmd),
        .i_sts          (dp_sts)
    );

    sha1bsh_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_data_byte   (i_data_byte),
        .o_sts         (dp_sts),
        .o_digest_word (o_digest_word)
    );

    // Input is never taken while a digest word is on offer
    `SHA1BSH_ASSERT_NOW(a_no_in_during_out, i_clk, i_rst_n, o_valid, o_stall, "input open during output")

    // A block write and a compression round never share a cycle
    `SHA1BSH_ASSERT_NOW(a_wr_vs_round, i_clk, i_rst_n, dp_cmd.byte_wr, !dp_cmd.round_en, "byte write during round")

    // A taken non-final word is followed by the next index
    `SHA1BSH_ASSERT_NEXT(a_idx_step, i_clk, i_rst_n, o_valid && !i_stall && !o_last_word, o_valid && (o_word_index == $past(o_word_index) + 3'd1), "digest index did not advance")

    // After the final word the block is ready for a new message
    `SHA1BSH_ASSERT_NEXT(a_ready_after_last, i_clk, i_rst_n, o_valid && !i_stall && o_last_word, !o_valid && !o_stall, "not ready after last word")

endmodule
